// ----- rtl/sgdlr_pkg.sv -----
// ----------------------------------------------------------------------------
// sgdlr_pkg: shared types and constants of the SGD linear regression trainer
// Widths of the shared multiplier and divider, their request and response
// structs, configuration register indexes and default parameter values.
// ----------------------------------------------------------------------------
package sgdlr_pkg;

	localparam int MAX_BATCH_DEF  = 256;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 2;
	localparam int MUL_W   = 32;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int DIV_W   = 64;
	localparam int CNT_W   = 9;

	typedef enum logic [CIDX_W-1:0] {
		REG_STEP_RATE   = 2'd0,
		REG_BATCH_COUNT = 2'd1,
		REG_INIT_WEIGHT = 2'd2,
		REG_INIT_BIAS   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                    en;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [DIV_W-1:0] mag;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- rtl/sgdlr_mul.sv -----
// ----------------------------------------------------------------------------
// sgdlr_mul: shared signed multiplier
// One 32 x 32 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module sgdlr_mul (
	input  logic                                   clk,
	input  sgdlr_pkg::mul_req_t                    req,
	output logic signed [sgdlr_pkg::PROD_W-1:0]    prod
);

	logic signed [sgdlr_pkg::PROD_W-1:0] prod_q;

	// hold the last product while idle
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= $signed(req.a) * $signed(req.b);
		end
	end

	assign prod = prod_q;

endmodule

// ----- rtl/sgdlr_div.sv -----
// ----------------------------------------------------------------------------
// sgdlr_div: iterative sign-magnitude divider
// Restoring division of a 64-bit magnitude by a small unsigned divisor, one
// quotient bit per cycle; the sign is applied to the quotient at the end.
// ----------------------------------------------------------------------------
module sgdlr_div (
	input  logic                clk,
	input  logic                arst_n,
	input  sgdlr_pkg::div_req_t req,
	output sgdlr_pkg::div_rsp_t rsp
);

	localparam int DW     = sgdlr_pkg::DIV_W;
	localparam int NW     = sgdlr_pkg::CNT_W;
	localparam int ITER_W = $clog2(DW);
	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(DW - 1);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [ITER_W-1:0] iter_q;
	logic [DW-1:0]     quo_q;
	logic [NW-1:0]     rem_q;
	logic [NW-1:0]     dvs_q;

	logic [NW:0]       trial;
	logic              ge;
	logic [NW:0]       trial_sub;

	assign trial     = {rem_q, quo_q[DW-1]};
	assign ge        = (trial >= {1'b0, dvs_q});
	assign trial_sub = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			// pulse done for one cycle after the last quotient bit
			done_q <= busy_q && !req.start && (iter_q == LAST_ITER);
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == LAST_ITER) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// shift dividend bits out and quotient bits in through the same register
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.mag;
			rem_q <= '0;
			dvs_q <= req.divisor;
			neg_q <= req.neg;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? trial_sub[NW-1:0] : trial[NW-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? (DW'(0) - quo_q) : quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (!busy_q && !done_q))
		else $error("divider started while busy");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && iter_q == LAST_ITER && !req.start) |=> (done_q && !busy_q))
		else $error("divider did not finish after the last quotient bit");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

// ----- rtl/sgd_linear_regression_trainer.sv -----
// ----------------------------------------------------------------------------
// sgd_linear_regression_trainer: minibatch SGD for y = weight*x + bias
// Accumulates squared error and both gradients over a batch of Q16.16
// samples, then averages them and steps weight and bias by the learn rate.
// ----------------------------------------------------------------------------
// Each accepted sample is followed by four steps; with the accept they pass
// three dependent products (weight*x, err*err, err*x) through the single
// shared 32x32 multiplier. sample_stall stays high until the state is back
// in S_IDLE, so no new sample is taken before the last one is through. At
// the end of a batch the three sums are averaged one after another on one
// bit-serial divider, then each parameter update runs S_MLO, S_MHI, S_STEP
// and S_APPLY on the same multiplier (the step is split into two partial
// products), and S_OUT loads the result register once per batch. A finished
// result waits in its own output register, so the next batch may start
// while it is still stalled; a second result waits until the first one has
// been taken. Configuration writes are meant for idle periods; writing the
// initial weight or bias also loads the live parameter at once, saturated
// to DATA_WIDTH bits, without touching the partial batch sums. A batch count
// of zero acts as one and a count above MAX_BATCH acts as MAX_BATCH.
// ----------------------------------------------------------------------------
module sgd_linear_regression_trainer #(
	parameter int MAX_BATCH  = sgdlr_pkg::MAX_BATCH_DEF,
	parameter int DATA_WIDTH = sgdlr_pkg::DATA_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_we,
	input  logic [sgdlr_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [sgdlr_pkg::CFG_W-1:0]          cfg_data,

	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [31:0]                   sample_x,
	input  logic signed [31:0]                   sample_y,

	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [31:0]                          mean_loss,
	output logic signed [31:0]                   new_weight,
	output logic signed [31:0]                   new_bias
);

	localparam int NW        = sgdlr_pkg::CNT_W;
	localparam int BATCH_CAP = (MAX_BATCH > (2**NW - 1)) ? (2**NW - 1) : MAX_BATCH;
	localparam logic [NW-1:0] BATCH_CAP_V = NW'(BATCH_CAP);

	// saturation bounds of a parameter value, held in the 50-bit work width
	localparam logic signed [49:0] SAT_HI = (50'sd1 <<< (DATA_WIDTH - 1)) - 50'sd1;
	localparam logic signed [49:0] SAT_LO = -SAT_HI - 50'sd1;

	// mean gradients are clamped to +-2^47 before the step
	localparam logic signed [63:0] GRAD_HI = 64'sd1 <<< 47;
	localparam logic signed [63:0] GRAD_LO = -GRAD_HI;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_ERR   = 11'b000_0000_0010,
		S_SQ    = 11'b000_0000_0100,
		S_LOSS  = 11'b000_0000_1000,
		S_GRAD  = 11'b000_0001_0000,
		S_DIV   = 11'b000_0010_0000,
		S_MLO   = 11'b000_0100_0000,
		S_MHI   = 11'b000_1000_0000,
		S_STEP  = 11'b001_0000_0000,
		S_APPLY = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		SRC_LOSS = 2'd0,
		SRC_WGT  = 2'd1,
		SRC_BIAS = 2'd2
	} div_src_t;

	function automatic logic [31:0] sat_data(input logic signed [49:0] v);
		logic signed [49:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end else begin
			r = v;
		end
		return r[31:0];
	endfunction

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

	// control and state
	state_t           state_q;
	div_src_t         src_q;
	logic             par_q;        // 0: weight update, 1: bias update
	logic [15:0]      rate_q;
	logic [NW-1:0]    bcount_q;
	logic [NW-1:0]    cnt_q;
	logic signed [31:0] weight_q;
	logic signed [31:0] bias_q;
	logic [63:0]      loss_q;
	logic [63:0]      wsum_q;
	logic [63:0]      bsum_q;
	logic             res_valid_q;

	// datapath payload
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] err_q;
	logic [31:0]        mloss_q;
	logic signed [48:0] gw_q;
	logic signed [48:0] gb_q;
	logic signed [63:0] acc_q;
	logic [31:0]        loss_out_q;
	logic signed [31:0] weight_out_q;
	logic signed [31:0] bias_out_q;

	// shared units
	sgdlr_pkg::mul_req_t mul_req;
	logic signed [sgdlr_pkg::PROD_W-1:0] prod;
	sgdlr_pkg::div_req_t div_req;
	sgdlr_pkg::div_rsp_t div_rsp;

	sgdlr_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	sgdlr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// effective batch size
	logic [NW-1:0] batch_n;
	logic [NW-1:0] cnt_inc;

	always_comb begin
		if (bcount_q == '0) begin
			batch_n = NW'(1);
		end else if (bcount_q > BATCH_CAP_V) begin
			batch_n = BATCH_CAP_V;
		end else begin
			batch_n = bcount_q;
		end
	end

	assign cnt_inc = cnt_q + 1'b1;

	// per-sample arithmetic: err = y - (bias + (weight*x >> 16)), saturated
	logic [48:0]  pred;
	logic [49:0]  err_diff;
	logic [31:0]  err_new;

	assign pred     = {{17{bias_q[31]}}, bias_q} + {prod[63], prod[63:16]};
	assign err_diff = {{18{y_q[31]}}, y_q} - {pred[48], pred};
	assign err_new  = sat_data($signed(err_diff));

	// loss term (err*err >> 16) into an unsigned saturating sum
	logic [64:0] lsum;
	logic [63:0] loss_next;

	assign lsum      = {1'b0, loss_q} + {17'd0, prod[63:16]};
	assign loss_next = lsum[64] ? {64{1'b1}} : lsum[63:0];

	// gradient terms: -(err*x >> 15) and -2*err
	logic [49:0] wterm;
	logic [63:0] bterm;

	assign wterm = 50'd0 - {prod[63], prod[63:15]};
	assign bterm = 64'd0 - {{31{err_q[31]}}, err_q, 1'b0};

	// divider feed
	always_comb begin
		div_req.start   = (state_q == S_DIV) && !div_rsp.busy && !div_rsp.done;
		div_req.divisor = batch_n;
		case (src_q)
			SRC_WGT: begin
				div_req.neg = wsum_q[63];
				div_req.mag = wsum_q[63] ? (64'd0 - wsum_q) : wsum_q;
			end
			SRC_BIAS: begin
				div_req.neg = bsum_q[63];
				div_req.mag = bsum_q[63] ? (64'd0 - bsum_q) : bsum_q;
			end
			default: begin
				div_req.neg = 1'b0;
				div_req.mag = loss_q;
			end
		endcase
	end

	logic signed [63:0] quot;
	logic [31:0]        mloss_sat;
	logic signed [48:0] grad_clamp;

	assign quot      = $signed(div_rsp.quot);
	assign mloss_sat = (div_rsp.quot[63:32] != '0) ? {32{1'b1}} : div_rsp.quot[31:0];

	always_comb begin
		if (quot > GRAD_HI) begin
			grad_clamp = GRAD_HI[48:0];
		end else if (quot < GRAD_LO) begin
			grad_clamp = GRAD_LO[48:0];
		end else begin
			grad_clamp = quot[48:0];
		end
	end

	// parameter update: step = (rate * g) >> 16, with g split at bit 24
	logic signed [48:0] grad_sel;
	logic signed [31:0] grad_lo;
	logic signed [31:0] grad_hi;
	logic signed [31:0] rate_ext;
	logic signed [31:0] param_cur;
	logic [49:0]        upd_diff;
	logic [31:0]        param_new;

	assign grad_sel  = par_q ? gb_q : gw_q;
	assign grad_lo   = $signed({8'd0, grad_sel[23:0]});
	assign grad_hi   = $signed({{7{grad_sel[48]}}, grad_sel[48:24]});
	assign rate_ext  = $signed({16'd0, rate_q});
	assign param_cur = par_q ? bias_q : weight_q;
	assign upd_diff  = {{18{param_cur[31]}}, param_cur} - {{2{acc_q[63]}}, acc_q[63:16]};
	assign param_new = sat_data($signed(upd_diff));

	// multiplier operand select; the multiplier registers each product before it is used
	always_comb begin
		mul_req.en = 1'b0;
		mul_req.a  = err_q;
		mul_req.b  = x_q;
		case (state_q)
			S_IDLE: begin
				mul_req.en = 1'b1;
				mul_req.a  = weight_q;
				mul_req.b  = sample_x;
			end
			S_SQ: begin
				mul_req.en = 1'b1;
				mul_req.a  = err_q;
				mul_req.b  = err_q;
			end
			S_LOSS: begin
				mul_req.en = 1'b1;
				mul_req.a  = err_q;
				mul_req.b  = x_q;
			end
			S_MLO: begin
				mul_req.en = 1'b1;
				mul_req.a  = rate_ext;
				mul_req.b  = grad_lo;
			end
			S_MHI: begin
				mul_req.en = 1'b1;
				mul_req.a  = rate_ext;
				mul_req.b  = grad_hi;
			end
			default: begin
				mul_req.en = 1'b0;
			end
		endcase
	end

	logic out_load;

	assign out_load = (state_q == S_OUT) && (!res_valid_q || !result_stall);

	// control, configuration and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			src_q       <= SRC_LOSS;
			par_q       <= 1'b0;
			rate_q      <= 16'd655;
			bcount_q    <= NW'(16);
			cnt_q       <= '0;
			weight_q    <= '0;
			bias_q      <= '0;
			loss_q      <= '0;
			wsum_q      <= '0;
			bsum_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// drop the result once it transfers, unless a new one loads below
			if (res_valid_q && !result_stall && !out_load) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_LOSS;
				end
				S_LOSS: begin
					loss_q  <= loss_next;
					state_q <= S_GRAD;
				end
				S_GRAD: begin
					wsum_q <= sat_add64(wsum_q, {{14{wterm[49]}}, wterm});
					bsum_q <= sat_add64(bsum_q, bterm);
					cnt_q  <= cnt_inc;
					if (cnt_inc >= batch_n) begin
						src_q   <= SRC_LOSS;
						state_q <= S_DIV;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						case (src_q)
							SRC_LOSS: src_q <= SRC_WGT;
							SRC_WGT:  src_q <= SRC_BIAS;
							default: begin
								// all three means taken: clear the batch
								src_q   <= SRC_LOSS;
								loss_q  <= '0;
								wsum_q  <= '0;
								bsum_q  <= '0;
								cnt_q   <= '0;
								par_q   <= 1'b0;
								state_q <= S_MLO;
							end
						endcase
					end
				end
				S_MLO: begin
					state_q <= S_MHI;
				end
				S_MHI: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (!par_q) begin
						weight_q <= param_new;
						par_q    <= 1'b1;
						state_q  <= S_MLO;
					end else begin
						bias_q  <= param_new;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_we) begin
				case (cfg_index)
					sgdlr_pkg::REG_STEP_RATE:   rate_q   <= cfg_data[15:0];
					sgdlr_pkg::REG_BATCH_COUNT: bcount_q <= cfg_data[NW-1:0];
					sgdlr_pkg::REG_INIT_WEIGHT:
						weight_q <= sat_data($signed({{18{cfg_data[31]}}, cfg_data}));
					sgdlr_pkg::REG_INIT_BIAS:
						bias_q <= sat_data($signed({{18{cfg_data[31]}}, cfg_data}));
					default: begin
					end
				endcase
			end
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && sample_valid) begin
			x_q <= sample_x;
			y_q <= sample_y;
		end
		if (state_q == S_ERR) begin
			err_q <= err_new;
		end
		if (state_q == S_DIV && div_rsp.done) begin
			if (src_q == SRC_LOSS) begin
				mloss_q <= mloss_sat;
			end else if (src_q == SRC_WGT) begin
				gw_q <= grad_clamp;
			end else begin
				gb_q <= grad_clamp;
			end
		end
		if (state_q == S_MHI) begin
			acc_q <= prod;
		end
		if (state_q == S_STEP) begin
			acc_q <= acc_q + {prod[39:0], 24'd0};
		end
		if (out_load) begin
			loss_out_q   <= mloss_q;
			weight_out_q <= weight_q;
			bias_out_q   <= bias_q;
		end
	end

	assign sample_stall = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign mean_loss    = loss_out_q;
	assign new_weight   = weight_out_q;
	assign new_bias     = bias_out_q;

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");

	a_batch_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MLO && !par_q) |-> (loss_q == '0 && wsum_q == '0 &&
			bsum_q == '0 && cnt_q == '0))
		else $error("batch sums not cleared before the update");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> (state_q == S_ERR))
		else $error("accepted sample did not start the error step");

	a_apply_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |=> (state_q == S_MLO || state_q == S_OUT))
		else $error("update sequence left its order");

endmodule
